>>> hdl/utce_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions for the UTC timestamp to epoch converter.
// No dependencies; the parser, queue, pipeline, top level and testbench refer to this package by scoped names.

package utce_pkg;

    // ASCII characters of the timestamp text.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Character positions; the final character of a well-formed string sits at POS_LAST.
    localparam logic [4:0] POS_LAST = 5'd19;
    localparam logic [4:0] POS_MAX  = 5'd31;

    localparam logic [13:0] YEAR_MIN      = 14'd1970;
    localparam logic [13:0] YEAR_MAX      = 14'd2105;
    localparam logic [13:0] YEAR_NO_LEAP  = 14'd2100;
    localparam logic [13:0] ERA_HI_START  = 14'd2000;
    localparam logic [13:0] ERA_LO_START  = 14'd1600;

    // Day-count offsets, taken modulo 2^20: era * 146097 - 719468 for eras 5 and 4.
    localparam logic [19:0] DAYS_OFS_ERA_HI = 20'd11017;
    localparam logic [19:0] DAYS_OFS_ERA_LO = 20'd913496;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    typedef enum logic [3:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_DASH,
        FLD_T,
        FLD_COLON,
        FLD_Z,
        FLD_NONE
    } t_fld;

    // One parsed timestamp as it travels from the parser to the arithmetic pipeline.
    typedef struct packed {
        logic        bad;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_rec;

    function automatic t_fld pos_class(input logic [4:0] pos);
        t_fld f;
        case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
            5'd5, 5'd6:             f = FLD_MONTH;
            5'd8, 5'd9:             f = FLD_DAY;
            5'd11, 5'd12:           f = FLD_HOUR;
            5'd14, 5'd15:           f = FLD_MINUTE;
            5'd17, 5'd18:           f = FLD_SECOND;
            5'd4, 5'd7:             f = FLD_DASH;
            5'd10:                  f = FLD_T;
            5'd13, 5'd16:           f = FLD_COLON;
            5'd19:                  f = FLD_Z;
            default:                f = FLD_NONE;
        endcase
        return f;
    endfunction

    function automatic logic [13:0] acc_dec14(input logic [13:0] acc, input logic [3:0] d);
        logic [13:0] r;
        r = (acc << 3) + (acc << 1) + {10'd0, d};
        return r;
    endfunction

    function automatic logic [6:0] acc_dec7(input logic [6:0] acc, input logic [3:0] d);
        logic [6:0] r;
        r = (acc << 3) + (acc << 1) + {3'd0, d};
        return r;
    endfunction

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] r;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
            7'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // First day of a month in a March-based year, (153 * mp + 2) / 5.
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/utce_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the character input and the epoch result.
// No dependencies.

interface utce_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface utce_epoch_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] epoch_seconds;

    modport source (output valid, output valid_res, output epoch_seconds, input ready);
    modport sink   (input valid, input valid_res, input epoch_seconds, output ready);
endinterface

>>> hdl/utce_parse.sv
`timescale 1ns / 1ps
// Front end: takes one character per transaction, checks its place and accumulates fields.
// Depends on utce_pkg and utce_char_if; pushes one t_rec per finished string.

module utce_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utce_char_if.sink          i_char,
    input  logic               i_full,
    output logic               o_push,
    output utce_pkg::t_rec     o_rec
);

    logic [4:0]  r_pos,    n_pos;
    logic [13:0] r_year,   n_year;
    logic [6:0]  r_month,  n_month;
    logic [6:0]  r_day,    n_day;
    logic [6:0]  r_hour,   n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic        r_ferr,   n_ferr;

    logic       acc;
    logic       is_digit;
    logic [3:0] digit;

    assign i_char.ready = !i_full;
    assign acc          = i_char.valid && i_char.ready;
    assign is_digit     = (i_char.char_byte >= utce_pkg::CH_0)
                       && (i_char.char_byte <= utce_pkg::CH_9);
    assign digit        = is_digit ? i_char.char_byte[3:0] : 4'd0;

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_ferr   = r_ferr;
        n_pos    = (r_pos == utce_pkg::POS_MAX) ? r_pos : r_pos + 5'd1;
        case (utce_pkg::pos_class(r_pos))
            utce_pkg::FLD_YEAR: begin
                n_year = utce_pkg::acc_dec14(r_year, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_MONTH: begin
                n_month = utce_pkg::acc_dec7(r_month, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_DAY: begin
                n_day = utce_pkg::acc_dec7(r_day, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_HOUR: begin
                n_hour = utce_pkg::acc_dec7(r_hour, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_MINUTE: begin
                n_minute = utce_pkg::acc_dec7(r_minute, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_SECOND: begin
                n_second = utce_pkg::acc_dec7(r_second, digit);
                if (!is_digit) n_ferr = 1'b1;
            end
            utce_pkg::FLD_DASH: begin
                if (i_char.char_byte != utce_pkg::CH_DASH) n_ferr = 1'b1;
            end
            utce_pkg::FLD_T: begin
                if (i_char.char_byte != utce_pkg::CH_T) n_ferr = 1'b1;
            end
            utce_pkg::FLD_COLON: begin
                if (i_char.char_byte != utce_pkg::CH_COLON) n_ferr = 1'b1;
            end
            utce_pkg::FLD_Z: begin
                if (i_char.char_byte != utce_pkg::CH_Z) n_ferr = 1'b1;
            end
            default: begin
                n_ferr = 1'b1;
            end
        endcase
    end

    // The record carries the fields as they stand after the final character.
    assign o_push        = acc && i_char.last_char;
    assign o_rec.bad     = n_ferr || (r_pos != utce_pkg::POS_LAST);
    assign o_rec.year    = n_year;
    assign o_rec.month   = n_month;
    assign o_rec.day     = n_day;
    assign o_rec.hour    = n_hour;
    assign o_rec.minute  = n_minute;
    assign o_rec.second  = n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos    <= 5'd0;
            r_year   <= 14'd0;
            r_month  <= 7'd0;
            r_day    <= 7'd0;
            r_hour   <= 7'd0;
            r_minute <= 7'd0;
            r_second <= 7'd0;
            r_ferr   <= 1'b0;
        end else if (acc) begin
            r_pos    <= n_pos;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_ferr   <= n_ferr;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == 5'd0) && !r_ferr && (r_year == 14'd0))
        else $error("parser state not cleared after the final character");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_char.last_char) |=>
            (r_pos == (($past(r_pos) == utce_pkg::POS_MAX) ? $past(r_pos)
                                                           : $past(r_pos) + 5'd1)))
        else $error("character position did not advance");

endmodule

>>> hdl/utce_fifo.sv
`timescale 1ns / 1ps
// Short record queue between the parser and the arithmetic pipeline.
// Depends on utce_pkg for the t_rec record type.

module utce_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  utce_pkg::t_rec i_wr_data,
    output logic           o_full,
    output logic           o_rd_valid,
    output utce_pkg::t_rec o_rd_data,
    input  logic           i_rd_en
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utce_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push, pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_en && !o_full;
    assign pop        = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond its depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow a write");

endmodule

>>> hdl/utce_calc.sv
`timescale 1ns / 1ps
// Back end: four-stage pipeline that range-checks a record and forms the epoch seconds.
// Depends on utce_pkg and utce_epoch_if; the last stage is the output register.

module utce_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  utce_pkg::t_rec i_rec,
    output logic           o_ready,
    utce_epoch_if.source   o_epoch
);

    logic [3:0] r_v;
    logic       adv;

    // Stage 1: checks and calendar reshaping.
    logic       r1_ok;
    logic [8:0] r1_yoe;
    logic       r1_era_hi;
    logic [3:0] r1_mp;
    logic [4:0] r1_day;
    logic [4:0] r1_hour;
    logic [5:0] r1_minute;
    logic [5:0] r1_second;
    // Stage 2: day count and seconds of the day.
    logic        r2_ok;
    logic [15:0] r2_days;
    logic [16:0] r2_hms;
    // Stage 3: whole days in seconds.
    logic        r3_ok;
    logic [32:0] r3_prod;
    logic [16:0] r3_hms;
    // Stage 4: output register.
    logic        r4_ok;
    logic [31:0] r4_epoch;

    logic        leap;
    logic        ok1;
    logic [13:0] y_adj;
    logic        era_hi;
    logic [13:0] yoe_w;
    logic [3:0]  mp;
    logic [1:0]  cent;
    logic [19:0] doe;
    logic [19:0] days_w;
    logic [16:0] hms;
    logic [33:0] sum;

    assign adv     = !r_v[3] || o_epoch.ready;
    assign o_ready = adv;

    // Within the accepted year range only 2100 breaks the four-year rule.
    assign leap = (i_rec.year[1:0] == 2'd0) && (i_rec.year != utce_pkg::YEAR_NO_LEAP);
    assign ok1  = !i_rec.bad
               && (i_rec.year >= utce_pkg::YEAR_MIN) && (i_rec.year <= utce_pkg::YEAR_MAX)
               && (i_rec.day != 7'd0)
               && (i_rec.day <= {2'd0, utce_pkg::month_days(i_rec.month, leap)})
               && (i_rec.hour <= 7'd23) && (i_rec.minute <= 7'd59)
               && (i_rec.second <= 7'd59);

    // Years start in March; January and February count with the year before.
    assign y_adj  = i_rec.year - ((i_rec.month <= 7'd2) ? 14'd1 : 14'd0);
    assign era_hi = (y_adj >= utce_pkg::ERA_HI_START);
    assign yoe_w  = y_adj - (era_hi ? utce_pkg::ERA_HI_START : utce_pkg::ERA_LO_START);
    assign mp     = (i_rec.month > 7'd2) ? 4'(i_rec.month - 7'd3) : 4'(i_rec.month + 7'd9);

    assign cent = (r1_yoe >= 9'd300) ? 2'd3 :
                  (r1_yoe >= 9'd200) ? 2'd2 :
                  (r1_yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign doe  = 20'(r1_yoe) * 20'(utce_pkg::DAYS_PER_YEAR)
                + 20'(r1_yoe >> 2) - 20'(cent)
                + 20'(utce_pkg::month_offset(r1_mp)) + 20'(r1_day) - 20'd1;
    assign days_w = doe + (r1_era_hi ? utce_pkg::DAYS_OFS_ERA_HI : utce_pkg::DAYS_OFS_ERA_LO);
    assign hms  = 17'(r1_hour) * 17'(utce_pkg::SEC_PER_HOUR)
                + 17'(r1_minute) * 17'(utce_pkg::SEC_PER_MIN) + 17'(r1_second);

    assign sum = 34'(r3_prod) + 34'(r3_hms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ok     <= ok1;
            r1_yoe    <= yoe_w[8:0];
            r1_era_hi <= era_hi;
            r1_mp     <= mp;
            r1_day    <= i_rec.day[4:0];
            r1_hour   <= i_rec.hour[4:0];
            r1_minute <= i_rec.minute[5:0];
            r1_second <= i_rec.second[5:0];

            r2_ok   <= r1_ok;
            r2_days <= days_w[15:0];
            r2_hms  <= hms;

            r3_ok   <= r2_ok;
            r3_prod <= 33'(r2_days) * 33'(utce_pkg::SEC_PER_DAY);
            r3_hms  <= r2_hms;

            r4_ok    <= r3_ok && (sum[33:32] == 2'd0);
            r4_epoch <= sum[31:0];
        end
    end

    assign o_epoch.valid         = r_v[3];
    assign o_epoch.valid_res     = r4_ok;
    assign o_epoch.epoch_seconds = r4_ok ? r4_epoch : 32'd0;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_v == $past(r_v)) && $stable(r4_epoch) && $stable(r4_ok))
        else $error("pipeline moved during a stall");

endmodule

>>> hdl/utc_timestamp_to_epoch.sv
`timescale 1ns / 1ps
// A finished string goes through the record queue into the four-stage arithmetic pipeline.
// Throughput: one character per cycle unless the queue is full, and one result per cycle
// while the output is ready; the record queue lets the parser run during output stalls.
// Reset: synchronous, active low; clears parser state, queue pointers and stage valids.
// Depends on utce_pkg, utce_if, utce_parse, utce_fifo and utce_calc.

module utc_timestamp_to_epoch #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utce_char_if.sink     i_char,
    utce_epoch_if.source  o_epoch
);

    logic           push;
    logic           full;
    logic           rd_valid;
    logic           calc_ready;
    utce_pkg::t_rec wr_rec;
    utce_pkg::t_rec rd_rec;

    utce_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (wr_rec)
    );

    utce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (push),
        .i_wr_data  (wr_rec),
        .o_full     (full),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_rec),
        .i_rd_en    (calc_ready)
    );

    utce_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_valid),
        .i_rec   (rd_rec),
        .o_ready (calc_ready),
        .o_epoch (o_epoch)
    );

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_epoch.valid && !o_epoch.valid_res) |-> (o_epoch.epoch_seconds == 32'd0))
        else $error("rejected timestamp carries a nonzero epoch");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utc_timestamp_to_epoch: streams timestamp text
// and predicts each epoch result.
// Depends on utce_pkg and utce_if, and on the RTL of the block under test.

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain_first;
    } t_text_char;

    typedef struct {
        logic        valid_res;
        logic [31:0] epoch_seconds;
    } t_epoch_result;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_STALLS} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    utce_char_if  char_ch ();
    utce_epoch_if epoch_ch ();

    utc_timestamp_to_epoch DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_epoch (epoch_ch)
    );

    always #10 i_clk = ~i_clk;

    t_text_char    text_chars[$];
    t_epoch_result expected_epochs[$];
    int            fail_cnt = 0;
    int            cycle_cnt = 0;

    // Parser state of the predictor.
    logic [4:0]  text_pos = '0;
    logic [13:0] year_acc = '0;
    logic [6:0]  month_acc = '0;
    logic [6:0]  day_acc = '0;
    logic [6:0]  hour_acc = '0;
    logic [6:0]  minute_acc = '0;
    logic [6:0]  second_acc = '0;
    logic        text_bad = 1'b0;

    function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
        bit leap_year;
        leap_year = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic longint unsigned unix_seconds(int unsigned yr, int unsigned mo,
                                                     int unsigned dy, int unsigned hh,
                                                     int unsigned mm, int unsigned ss);
        longint unsigned y, era, yoe, mp, doy, doe, days;
        // The year is shifted so that it starts in March; leap days then fall at its end.
        y = longint'(yr) - ((mo <= 2) ? 1 : 0);
        era = y / 400;
        yoe = y - era * 400;
        mp = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + dy - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        return days * 86400 + longint'(hh) * 3600 + longint'(mm) * 60 + longint'(ss);
    endfunction

    task automatic take_timestamp_char(input logic [7:0] c, input logic last);
        logic            is_digit;
        logic [3:0]      d;
        logic [4:0]      at;
        logic            ok;
        longint unsigned secs;
        t_epoch_result   res;
        is_digit = (c >= utce_pkg::CH_0) && (c <= utce_pkg::CH_9);
        d = is_digit ? 4'(c - utce_pkg::CH_0) : 4'd0;
        at = text_pos;
        case (at)
            0, 1, 2, 3: begin
                year_acc = 14'(year_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            5, 6: begin
                month_acc = 7'(month_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            8, 9: begin
                day_acc = 7'(day_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            11, 12: begin
                hour_acc = 7'(hour_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            14, 15: begin
                minute_acc = 7'(minute_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            17, 18: begin
                second_acc = 7'(second_acc * 10 + d);
                if (!is_digit) text_bad = 1'b1;
            end
            4, 7:   if (c != utce_pkg::CH_DASH) text_bad = 1'b1;
            10:     if (c != utce_pkg::CH_T) text_bad = 1'b1;
            13, 16: if (c != utce_pkg::CH_COLON) text_bad = 1'b1;
            19:     if (c != utce_pkg::CH_Z) text_bad = 1'b1;
            default: text_bad = 1'b1;
        endcase
        if (text_pos != utce_pkg::POS_MAX) text_pos = text_pos + 5'd1;
        if (last) begin
            ok = (at == utce_pkg::POS_LAST) && !text_bad
                && (year_acc >= utce_pkg::YEAR_MIN) && (year_acc <= utce_pkg::YEAR_MAX)
                && (day_acc >= 1) && (day_acc <= month_length(year_acc, month_acc))
                && (hour_acc <= 23) && (minute_acc <= 59) && (second_acc <= 59);
            secs = 0;
            if (ok) begin
                secs = unix_seconds(year_acc, month_acc, day_acc, hour_acc, minute_acc,
                                    second_acc);
                if (secs > 64'hFFFF_FFFF) ok = 1'b0;
            end
            res.valid_res = ok;
            res.epoch_seconds = ok ? secs[31:0] : 32'd0;
            expected_epochs.push_back(res);
            text_pos = '0;
            year_acc = '0;
            month_acc = '0;
            day_acc = '0;
            hour_acc = '0;
            minute_acc = '0;
            second_acc = '0;
            text_bad = 1'b0;
        end
    endtask

    // Queues one string; one character may be replaced and random bytes may follow the text.
    task automatic push_text(input string s, input int bad_at, input logic [7:0] bad_byte,
                             input int extra, input bit drain);
        t_text_char item;
        int         total;
        total = s.len() + extra;
        for (int i = 0; i < total; i++) begin
            item.ch = (i >= s.len()) ? 8'($urandom) : ((i == bad_at) ? bad_byte : s[i]);
            item.last = (i == total - 1);
            item.drain_first = drain && (i == 0);
            text_chars.push_back(item);
        end
    endtask

    function automatic int unsigned edge_pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Builds a well-shaped timestamp; with spoil set, one field is redrawn, mostly out of range.
    function automatic string random_timestamp(bit spoil);
        int unsigned yr, mo, dy, hh, mi, ss;
        yr = edge_pick(1970, 2105);
        mo = edge_pick(1, 12);
        dy = edge_pick(1, month_length(yr, mo));
        hh = edge_pick(0, 23);
        mi = edge_pick(0, 59);
        ss = edge_pick(0, 59);
        if (spoil) begin
            case ($urandom_range(0, 5))
                0: yr = ($urandom_range(0, 1) == 0) ? 1969 + 137 * $urandom_range(0, 1)
                                                    : $urandom_range(0, 9999);
                1: mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
                2: dy = ($urandom_range(0, 1) == 0) ? 0
                                                    : $urandom_range(month_length(yr, mo) + 1,
                                                                     99);
                3: hh = $urandom_range(24, 99);
                4: mi = $urandom_range(60, 99);
                default: ss = $urandom_range(60, 99);
            endcase
        end
        return $sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", yr, mo, dy, hh, mi, ss);
    endfunction

    // Sender: bursts of transactions with random gaps in between.
    t_text_char cur_char;
    bit         holding = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.valid <= 1'b0;
            char_ch.char_byte <= 8'h00;
            char_ch.last_char <= 1'b0;
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                take_timestamp_char(cur_char.ch, cur_char.last);
                holding = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (text_chars.size() > 0
                             && !(text_chars[0].drain_first && expected_epochs.size() > 0)) begin
                    cur_char = text_chars.pop_front();
                    holding = 1'b1;
                end
            end
            char_ch.valid <= holding;
            char_ch.char_byte <= holding ? cur_char.ch : 8'($urandom);
            char_ch.last_char <= holding ? cur_char.last : 1'($urandom);
        end
    end

    // Receiver: switches at random among open, coin-flip, sparse and burst-stall patterns.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       stall_left = 0;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            epoch_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom);
                RX_SPARSE: rdy = (rx_left % 4 == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 16);
                    end
                end
            endcase
            epoch_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        t_epoch_result want;
        if (i_rst_n && epoch_ch.valid && epoch_ch.ready) begin
            if (expected_epochs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual valid_res %0b epoch %0d",
                         $time, epoch_ch.valid_res, epoch_ch.epoch_seconds);
                fail_cnt++;
            end else begin
                want = expected_epochs.pop_front();
                if (epoch_ch.valid_res !== want.valid_res) begin
                    $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                             $time, want.valid_res, epoch_ch.valid_res);
                    fail_cnt++;
                end
                if (epoch_ch.epoch_seconds !== want.epoch_seconds) begin
                    $display("%0t: epoch_seconds mismatch: expected %0d, actual %0d",
                             $time, want.epoch_seconds, epoch_ch.epoch_seconds);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int    rand_chars;
        int    rand_results;
        int    kind;
        int    cut;
        bit    drain;
        string s;

        // Epoch extremes, leap years and every range boundary.
        push_text("1970-01-01T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2105-12-31T23:59:59Z", -1, 8'h00, 0, 0);
        push_text("2000-02-29T12:34:56Z", -1, 8'h00, 0, 0);
        push_text("2100-02-29T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2104-02-29T23:59:59Z", -1, 8'h00, 0, 0);
        push_text("1969-12-31T23:59:59Z", -1, 8'h00, 0, 0);
        push_text("2106-01-01T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-00-10T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-13-01T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-04-31T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-05-00T24:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-05-01T23:60:00Z", -1, 8'h00, 0, 0);
        push_text("2024-05-01T23:59:60Z", -1, 8'h00, 0, 0);
        push_text("9999-99-99T99:99:99Z", -1, 8'h00, 0, 0);
        push_text("0000-00-00T00:00:00Z", -1, 8'h00, 0, 0);
        // Separators out of place, then signs, spaces and the byte extremes in digit fields.
        push_text("2024/01-01T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-01-01 00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-01-01T00.00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-01-01T00:00:00z", -1, 8'h00, 0, 0);
        push_text("20 4-+1-01T00:00:00Z", -1, 8'h00, 0, 0);
        push_text("2024-01-01T00:00:00Z", 2, 8'hFF, 0, 0);
        push_text("2024-01-01T00:00:00Z", 9, 8'h00, 0, 0);
        // Wrong lengths: one short, a lone final character, and overlong past saturation.
        push_text("2024-01-01T00:00:00", -1, 8'h00, 0, 0);
        push_text("Z", -1, 8'h00, 0, 0);
        push_text("2024-01-01T00:00:00Z", -1, 8'h00, 20, 0);

        // The directed characters count toward the total.
        rand_chars = text_chars.size();
        rand_results = 0;
        while (rand_chars < 900 || rand_results < 12) begin
            kind = $urandom_range(0, 99);
            // The first random string waits until the directed results are all in.
            drain = (rand_results == 0) || ($urandom_range(0, 19) == 0);
            s = random_timestamp(kind >= 60 && kind < 75);
            if (kind < 75) begin
                push_text(s, -1, 8'h00, 0, drain);
                rand_chars += s.len();
            end else if (kind < 85) begin
                push_text(s, $urandom_range(0, 19), 8'($urandom), 0, drain);
                rand_chars += s.len();
            end else if (kind < 93) begin
                cut = $urandom_range(1, 19);
                push_text(s.substr(0, cut - 1), -1, 8'h00, 0, drain);
                rand_chars += cut;
            end else begin
                cut = $urandom_range(1, 15);
                push_text(s, -1, 8'h00, cut, drain);
                rand_chars += s.len() + cut;
            end
            rand_results++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (text_chars.size() > 0 || holding || expected_epochs.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && expected_epochs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
